FILE: hw/rtl/nqhc_pkg.sv
`timescale 1ns / 1ps

package nqhc_pkg;

   // default board capacity
   localparam int MAX_N_DEF = 32;

   // field widths of the channels and the csr
   localparam int KIND_W = 1;
   localparam int COL_W  = 5;
   localparam int ROW_W  = 5;
   localparam int CONF_W = 9;
   localparam int SIZE_W = 6;

   // packed stream widths, padded to whole bytes
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 16;

   // bit positions inside rsp_tdata
   localparam int RSP_IMP_BIT = CONF_W;

   // board size after reset
   localparam logic [SIZE_W-1:0] SIZE_RST = 6'd8;

   // score ceiling
   localparam int SCORE_MAX = 511;

endpackage

FILE: hw/rtl/n_queens_hill_climb.sv
`timescale 1ns / 1ps

// channel   dir  handshake              payload
// req       in   req_tvalid/req_tready  tuser: kind; tdata: column[4:0], row[9:5]
// rsp       out  rsp_tvalid/rsp_tready  tdata: conflicts[8:0], improved[9]
// csr       in   csr_wen                csr_wdata: size in use[5:0]
//
// one transaction is worked at a time; the queen rows live in a memory with one
// write and one registered read port; every attack check reads one column per
// cycle from it. load: the write, then a full rescore, then the response.
// climb: a full rescore, then per column a base scan and one scan per trial row.
// synchronous active-high reset clears control and sets the board size to 8;
// the queen memory is not cleared. a new request is taken while the last
// response still waits; the block then holds its next response until rsp drains.
module n_queens_hill_climb #(
   parameter int MAX_N = nqhc_pkg::MAX_N_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   // request: tuser = kind
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [nqhc_pkg::KIND_W-1:0]      req_tuser,
   // request: tdata = column[4:0], row[9:5], zero pad
   input  logic [nqhc_pkg::REQ_DATA_W-1:0]  req_tdata,
   // response: tdata = conflicts[8:0], improved[9], zero pad
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [nqhc_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // board size register
   input  logic                             csr_wen,
   input  logic [nqhc_pkg::SIZE_W-1:0]      csr_wdata
);
   import nqhc_pkg::*;

   localparam int CW = (MAX_N > 1) ? $clog2(MAX_N) : 1;
   localparam int NW = $clog2(MAX_N + 1);
   localparam int RW = (CW > ROW_W) ? CW : ROW_W;
   localparam int SW = $clog2(MAX_N * (MAX_N - 1) / 2 + 1);

   // sequencer states
   localparam logic [3:0] ST_IDLE      = 4'd0;
   localparam logic [3:0] ST_FULL_NEXT = 4'd1;
   localparam logic [3:0] ST_FI_RD     = 4'd2;
   localparam logic [3:0] ST_FI_WT     = 4'd3;
   localparam logic [3:0] ST_SCAN      = 4'd4;
   localparam logic [3:0] ST_EVAL      = 4'd5;
   localparam logic [3:0] ST_C_RD      = 4'd6;
   localparam logic [3:0] ST_C_WT      = 4'd7;
   localparam logic [3:0] ST_K_START   = 4'd8;
   localparam logic [3:0] ST_FIN       = 4'd9;

   // what a finished scan feeds
   localparam logic [1:0] PH_FULL  = 2'd0;
   localparam logic [1:0] PH_BASE  = 2'd1;
   localparam logic [1:0] PH_TRIAL = 2'd2;

   localparam logic KIND_LOAD = 1'b0;

   logic [3:0]        state_ff, state_in;
   logic [1:0]        phase_ff, phase_in;
   logic              climb_ff, climb_in;
   logic [NW-1:0]     i_ff, i_in;
   logic [NW-1:0]     c_ff, c_in;
   logic [NW-1:0]     k_ff, k_in;
   logic [NW-1:0]     j_ff, j_in;
   logic [NW-1:0]     pj_ff, pj_in;
   logic              pend_ff, pend_in;
   logic [NW-1:0]     p_ff, p_in;
   logic [RW-1:0]     piv_ff, piv_in;
   logic [RW-1:0]     kept_ff, kept_in;
   logic [SW-1:0]     cnt_ff, cnt_in;
   logic [SW-1:0]     base_ff, base_in;
   logic [SW-1:0]     total_ff, total_in;
   logic [CONF_W-1:0] start_sat_ff, start_sat_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [CONF_W-1:0] rsp_conf_ff, rsp_conf_in;
   logic              rsp_imp_ff, rsp_imp_in;
   logic [SIZE_W-1:0] size_csr_ff;

   // queen row memory
   logic [RW-1:0]     queen_rows_ff [MAX_N];
   logic [RW-1:0]     rd_data_ff;
   logic [CW-1:0]     rd_addr;
   logic              mem_we;
   logic [CW-1:0]     mem_wa;
   logic [RW-1:0]     mem_wd;

   logic [NW-1:0]     n_use;
   logic [NW-1:0]     col_gap;
   logic              issue;
   logic [SW-1:0]     s_trial;
   logic [COL_W-1:0]  req_col;
   logic [ROW_W-1:0]  req_row;

   function automatic logic attack(input logic [RW-1:0] ra, input logic [RW-1:0] rb,
                                   input logic [NW-1:0] dd);
      logic [RW-1:0] d;
      d = (ra > rb) ? ra - rb : rb - ra;
      return (d == '0) || (int'(d) == int'(dd));
   endfunction

   function automatic logic [CONF_W-1:0] sat(input logic [SW-1:0] x);
      if (int'(x) > SCORE_MAX) begin
         return CONF_W'(SCORE_MAX);
      end
      return CONF_W'(x);
   endfunction

   // request fields
   assign req_col = req_tdata[COL_W-1:0];
   assign req_row = req_tdata[COL_W+ROW_W-1:COL_W];

   // columns and rows in use
   always_comb begin
      if (int'(size_csr_ff) > MAX_N) begin
         n_use = NW'(MAX_N);
      end else begin
         n_use = NW'(size_csr_ff);
      end
   end

   // column distance of the compare in flight
   assign col_gap = (p_ff > pj_ff) ? p_ff - pj_ff : pj_ff - p_ff;
   assign issue   = j_ff < n_use;
   assign s_trial = total_ff - base_ff + cnt_ff;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - CONF_W - 1){1'b0}}, rsp_imp_ff, rsp_conf_ff};

   // sequencer
   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      climb_in     = climb_ff;
      i_in         = i_ff;
      c_in         = c_ff;
      k_in         = k_ff;
      j_in         = j_ff;
      pj_in        = pj_ff;
      pend_in      = pend_ff;
      p_in         = p_ff;
      piv_in       = piv_ff;
      kept_in      = kept_ff;
      cnt_in       = cnt_ff;
      base_in      = base_ff;
      total_in     = total_ff;
      start_sat_in = start_sat_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_conf_in  = rsp_conf_ff;
      rsp_imp_in   = rsp_imp_ff;
      rd_addr      = j_ff[CW-1:0];
      mem_we       = 1'b0;
      mem_wa       = CW'(req_col);
      mem_wd       = RW'(req_row);

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               climb_in = (req_tuser[0] != KIND_LOAD);
               mem_we   = (req_tuser[0] == KIND_LOAD) && (int'(req_col) < MAX_N);
               i_in     = '0;
               cnt_in   = '0;
               phase_in = PH_FULL;
               state_in = ST_FULL_NEXT;
            end
         end
         // full rescore: one pivot column after another
         ST_FULL_NEXT: begin
            if ((i_ff + NW'(1)) < n_use) begin
               state_in = ST_FI_RD;
            end else begin
               total_in     = cnt_ff;
               start_sat_in = sat(cnt_ff);
               c_in         = '0;
               state_in     = climb_ff ? ST_C_RD : ST_FIN;
            end
         end
         ST_FI_RD: begin
            rd_addr  = i_ff[CW-1:0];
            state_in = ST_FI_WT;
         end
         ST_FI_WT: begin
            piv_in   = rd_data_ff;
            p_in     = i_ff;
            j_in     = i_ff + NW'(1);
            pend_in  = 1'b0;
            state_in = ST_SCAN;
         end
         // stream the other columns through the attack check
         ST_SCAN: begin
            if (issue) begin
               j_in = j_ff + NW'(1);
            end
            pend_in = issue;
            pj_in   = j_ff;
            if (pend_ff && (pj_ff != p_ff) && attack(piv_ff, rd_data_ff, col_gap)) begin
               cnt_in = cnt_ff + SW'(1);
            end
            if (!issue && !pend_ff) begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            case (phase_ff)
               PH_FULL: begin
                  i_in     = i_ff + NW'(1);
                  state_in = ST_FULL_NEXT;
               end
               PH_BASE: begin
                  base_in  = cnt_ff;
                  k_in     = '0;
                  state_in = ST_K_START;
               end
               PH_TRIAL: begin
                  // keep only a strict drop of the saturated score
                  if ((cnt_ff < base_ff) && (int'(s_trial) < SCORE_MAX)) begin
                     total_in = s_trial;
                     base_in  = cnt_ff;
                     kept_in  = piv_ff;
                  end
                  k_in     = k_ff + NW'(1);
                  state_in = ST_K_START;
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end
         // climb: one column at a time
         ST_C_RD: begin
            rd_addr = c_ff[CW-1:0];
            if (c_ff >= n_use) begin
               state_in = ST_FIN;
            end else begin
               state_in = ST_C_WT;
            end
         end
         ST_C_WT: begin
            kept_in  = rd_data_ff;
            piv_in   = rd_data_ff;
            p_in     = c_ff;
            j_in     = '0;
            cnt_in   = '0;
            pend_in  = 1'b0;
            phase_in = PH_BASE;
            state_in = ST_SCAN;
         end
         ST_K_START: begin
            if (k_ff >= n_use) begin
               mem_we   = 1'b1;
               mem_wa   = c_ff[CW-1:0];
               mem_wd   = kept_ff;
               c_in     = c_ff + NW'(1);
               state_in = ST_C_RD;
            end else begin
               piv_in   = RW'(k_ff);
               p_in     = c_ff;
               j_in     = '0;
               cnt_in   = '0;
               pend_in  = 1'b0;
               phase_in = PH_TRIAL;
               state_in = ST_SCAN;
            end
         end
         // hand the result to the output register once it is free
         ST_FIN: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_conf_in  = sat(total_ff);
               rsp_imp_in   = sat(total_ff) < start_sat_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         size_csr_ff  <= SIZE_RST;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wen) begin
            size_csr_ff <= csr_wdata;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      phase_ff     <= phase_in;
      climb_ff     <= climb_in;
      i_ff         <= i_in;
      c_ff         <= c_in;
      k_ff         <= k_in;
      j_ff         <= j_in;
      pj_ff        <= pj_in;
      p_ff         <= p_in;
      piv_ff       <= piv_in;
      kept_ff      <= kept_in;
      cnt_ff       <= cnt_in;
      base_ff      <= base_in;
      total_ff     <= total_in;
      start_sat_ff <= start_sat_in;
      rsp_conf_ff  <= rsp_conf_in;
      rsp_imp_ff   <= rsp_imp_in;
   end

   // queen row memory, one write and one registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         queen_rows_ff[mem_wa] <= mem_wd;
      end
      rd_data_ff <= queen_rows_ff[rd_addr];
   end

endmodule

FILE: hw/rtl/nqhc_checker.sv
`timescale 1ns / 1ps

module nqhc_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [nqhc_pkg::RSP_DATA_W-1:0]  rsp_tdata
);
   import nqhc_pkg::*;

   // a stalled response stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("rsp_tvalid dropped while stalled");

   // a stalled response keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("rsp_tdata changed while stalled");

   // reset leaves no response pending
   a_rst_clear: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response pending after reset");

   // an improving climb ends below the score ceiling
   a_imp_score: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[RSP_IMP_BIT] |-> rsp_tdata[CONF_W-1:0] != CONF_W'(SCORE_MAX))
      else $error("improved set at saturated score");

   // an accepted transaction keeps the block busy on the next cycle
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken back to back");

endmodule

bind n_queens_hill_climb nqhc_checker u_nqhc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

FILE: bench/nqhc_tb_pkg.sv
`timescale 1ns / 1ps

package nqhc_tb_pkg;

   // what a request transaction asks the block to do (travels in req_tuser)
   typedef enum logic [nqhc_pkg::KIND_W-1:0] {
      KIND_LOAD  = 1'b0,
      KIND_CLIMB = 1'b1
   } req_kind_type;

endpackage

FILE: bench/n_queens_checker.sv
`timescale 1ns / 1ps

module n_queens_checker
   import nqhc_pkg::*;
   import nqhc_tb_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   // tuser = kind
   input  logic [KIND_W-1:0]      req_tuser,
   // tdata = column[4:0], row[9:5], zero pad
   input  logic [REQ_DATA_W-1:0]  req_tdata,
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // tdata = conflicts[8:0], improved[9], zero pad
   input  logic [RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                   csr_wen,
   input  logic [SIZE_W-1:0]      csr_wdata,
   output int                     outstanding,
   output int                     fail_count
);

   localparam int BOARD_CAP = MAX_N_DEF;

   typedef struct packed {
      logic [CONF_W-1:0] conflicts;
      logic              improved;
   } score_rsp_type;

   // shadow copy of the board and the size register
   logic [ROW_W-1:0]  board_rows [BOARD_CAP];
   logic [SIZE_W-1:0] size_csr;
   logic [CONF_W-1:0] board_score;

   // scores still owed by the block, oldest first
   score_rsp_type score_rsp_q [$];
   score_rsp_type seen_rsp;
   score_rsp_type oldest_rsp;
   int            mismatches = 0;

   // columns that take part in scoring, saturated at the board capacity
   function automatic int unsigned columns_in_use();
      return (size_csr > BOARD_CAP) ? BOARD_CAP : size_csr;
   endfunction

   // attacking pairs among the first n columns: same row or same diagonal
   function automatic int unsigned attack_pairs(int unsigned n);
      int unsigned pairs;
      int unsigned ri;
      int unsigned rj;
      int unsigned row_gap;
      pairs = 0;
      for (int unsigned i = 0; i < n; i++) begin
         for (int unsigned j = i + 1; j < n; j++) begin
            ri = board_rows[i];
            rj = board_rows[j];
            row_gap = (ri > rj) ? ri - rj : rj - ri;
            if (row_gap == 0 || row_gap == j - i)
               pairs++;
         end
      end
      return (pairs > SCORE_MAX) ? SCORE_MAX : pairs;
   endfunction

   // apply one request to the shadow board and return the score it yields
   function automatic score_rsp_type score_after(req_kind_type kind, logic [COL_W-1:0] col,
                                                 logic [ROW_W-1:0] row);
      int unsigned      n;
      int unsigned      start_score;
      int unsigned      best_score;
      int unsigned      trial_score;
      logic [ROW_W-1:0] kept_row;
      score_rsp_type    rsp;
      n = columns_in_use();
      rsp.improved = 1'b0;
      if (kind == KIND_LOAD) begin
         if (int'(col) < BOARD_CAP)
            board_rows[col] = row;
         board_score = CONF_W'(attack_pairs(n));
      end else begin
         // best-row pass, column by column, trial row restored when not kept
         start_score = attack_pairs(n);
         best_score  = start_score;
         for (int unsigned c = 0; c < n; c++) begin
            kept_row = board_rows[c];
            for (int unsigned k = 0; k < n; k++) begin
               board_rows[c] = ROW_W'(k);
               trial_score = attack_pairs(n);
               if (trial_score < best_score) begin
                  best_score = trial_score;
                  kept_row   = ROW_W'(k);
               end
               board_rows[c] = kept_row;
            end
         end
         board_score  = CONF_W'(best_score);
         rsp.improved = (best_score < start_score);
      end
      rsp.conflicts = board_score;
      return rsp;
   endfunction

   // compare responses first, then predict new requests, then track the size register
   always @(posedge clock) begin
      if (reset) begin
         size_csr    = SIZE_RST;
         board_score = '0;
         score_rsp_q.delete();
         for (int i = 0; i < BOARD_CAP; i++)
            board_rows[i] = '0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            seen_rsp.conflicts = rsp_tdata[CONF_W-1:0];
            seen_rsp.improved  = rsp_tdata[RSP_IMP_BIT];
            if (score_rsp_q.size() == 0) begin
               $display("%0t: unexpected response, expected none, got conflicts %0d improved %0d",
                        $time, seen_rsp.conflicts, seen_rsp.improved);
               mismatches++;
            end else begin
               oldest_rsp = score_rsp_q.pop_front();
               if (seen_rsp.conflicts !== oldest_rsp.conflicts) begin
                  $display("%0t: conflicts mismatch, expected %0d, got %0d",
                           $time, oldest_rsp.conflicts, seen_rsp.conflicts);
                  mismatches++;
               end
               if (seen_rsp.improved !== oldest_rsp.improved) begin
                  $display("%0t: improved mismatch, expected %0d, got %0d",
                           $time, oldest_rsp.improved, seen_rsp.improved);
                  mismatches++;
               end
            end
         end
         if (req_tvalid && req_tready)
            score_rsp_q.push_back(score_after(req_kind_type'(req_tuser),
                                              req_tdata[COL_W-1:0],
                                              req_tdata[COL_W +: ROW_W]));
         if (csr_wen)
            size_csr = csr_wdata;
      end
      outstanding <= score_rsp_q.size();
      fail_count  <= mismatches;
   end

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import nqhc_pkg::*;
   import nqhc_tb_pkg::*;

   localparam int BOARD_CAP   = MAX_N_DEF;
   localparam int QUIET_LIMIT = 200000;
   localparam int SETTLE      = 4;

   logic                  clock;
   logic                  reset       = 1'b1;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   logic [KIND_W-1:0]     req_tuser   = '0;
   logic [REQ_DATA_W-1:0] req_tdata   = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_wen     = 1'b0;
   logic [SIZE_W-1:0]     csr_wdata   = '0;

   int outstanding;
   int fail_count;
   int sender_idle_pct   = 0;
   int receiver_idle_pct = 0;
   int quiet_cycles      = 0;
   int board_n           = 8;

   n_queens_hill_climb i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata)
   );

   n_queens_checker i_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tuser   (req_tuser),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wen     (csr_wen),
      .csr_wdata   (csr_wdata),
      .outstanding (outstanding),
      .fail_count  (fail_count)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // receiver back-pressure
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= receiver_idle_pct);
   end

   // watchdog on cycles with no transaction on either channel
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // one request transaction, with random idle cycles ahead of it
   task automatic send_req(req_kind_type kind, logic [COL_W-1:0] col, logic [ROW_W-1:0] row);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= REQ_DATA_W'({row, col});
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
   endtask

   task automatic load_queen(logic [COL_W-1:0] col, logic [ROW_W-1:0] row);
      send_req(KIND_LOAD, col, row);
   endtask

   // column and row fields are don't-care for a climb, so fill them with noise
   task automatic run_climb();
      send_req(KIND_CLIMB, COL_W'($urandom), ROW_W'($urandom));
   endtask

   // block is idle once every response is back
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_size(int unsigned size);
      wait_idle();
      csr_wen   <= 1'b1;
      csr_wdata <= SIZE_W'(size);
      @(posedge clock);
      csr_wen   <= 1'b0;
      @(posedge clock);
      board_n = (size > BOARD_CAP) ? BOARD_CAP : size;
   endtask

   // mostly inside the board, sometimes anywhere in the field range
   function automatic logic [4:0] pick_index(int n);
      if (n == 0 || $urandom_range(3) == 0)
         return 5'($urandom_range(31));
      return 5'($urandom_range(n - 1));
   endfunction

   // bursts of loads followed by climb passes, with occasional size changes
   task automatic random_traffic(int items, int lo, int hi);
      int sent;
      int burst;
      sent = 0;
      write_size($urandom_range(hi, lo));
      while (sent < items) begin
         burst = $urandom_range(6, 1);
         repeat (burst) begin
            load_queen(pick_index(board_n), pick_index(board_n));
            sent++;
         end
         repeat ($urandom_range(2, 1)) begin
            run_climb();
            sent++;
         end
         if ($urandom_range(5) == 0)
            write_size($urandom_range(hi, lo));
      end
   endtask

   // stimulus
   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      sender_idle_pct   = 37;
      receiver_idle_pct = 69;

      // fill every column while nothing is scored, so no unwritten row is ever read
      write_size(0);
      for (int c = 0; c < BOARD_CAP; c++)
         load_queen(COL_W'(c), (c == 0) ? 5'd31 : (c == BOARD_CAP - 1) ? 5'd0
                                        : 5'($urandom_range(31)));
      run_climb();

      // single-column board: never any attack
      write_size(1);
      load_queen(5'd0, 5'd31);
      run_climb();

      // smallest real board, row and column beyond the board
      write_size(4);
      load_queen(5'd0, 5'd0);
      load_queen(5'd1, 5'd1);
      load_queen(5'd2, 5'd31);
      load_queen(5'd31, 5'd5);
      run_climb();
      run_climb();

      // size above capacity saturates, one full-size climb
      write_size(63);
      load_queen(5'd31, 5'd31);
      run_climb();

      write_size(32);
      load_queen(5'd0, 5'd0);

      // repeated passes on the default size
      write_size(8);
      load_queen(5'd3, 5'd3);
      run_climb();
      run_climb();
      run_climb();

      random_traffic(18, 4, 10);

      sender_idle_pct   = 69;
      receiver_idle_pct = 37;
      random_traffic(18, 0, 14);

      sender_idle_pct   = 0;
      receiver_idle_pct = 0;
      random_traffic(16, 4, 12);

      wait_idle();
      repeat (200) @(posedge clock);
      if (fail_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
